// ----- rtl/core/i2da_pkg.sv -----
package i2da_pkg;

   // Width of the fixed fields on the ports
   localparam int RAW_W  = 64;
   localparam int CHAR_W = 8;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIGN,
      ST_CONV,
      ST_SKIP,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;        // capture operand, clear BCD, start bit counter
      logic shift;       // one double-dabble step
      logic skip;        // drop a leading zero digit
      logic emit_sign;   // load '-' into the output register
      logic emit_digit;  // load top digit into the output register and advance
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic neg;         // operand is negative
      logic last_shift;  // current shift is the final one
      logic top_zero;    // most significant remaining digit is zero
      logic one_left;    // exactly one digit remains
   } status_type;

endpackage

// ----- rtl/core/i2da_datapath.sv -----
module i2da_datapath #(
   parameter int VALUE_BITS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [i2da_pkg::RAW_W-1:0]   raw_value,
   input  logic                         sign_mode,
   input  i2da_pkg::cmd_type            cmd,
   output i2da_pkg::status_type         sts,
   output logic [i2da_pkg::CHAR_W-1:0]  out_char,
   output logic                         out_last
);
   import i2da_pkg::*;

   // Decimal digits of the largest unsigned operand: floor(N*log10(2)) + 1
   localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BCD_W  = DIGITS * 4;
   localparam int CNT_W  = $clog2(VALUE_BITS + 1);
   localparam int DIG_W  = $clog2(DIGITS + 1);

   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [CNT_W-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [DIG_W-1:0]      dig_cnt_ff, dig_cnt_in;
   logic                  neg_ff, neg_in;
   logic [CHAR_W-1:0]     char_ff, char_in;
   logic                  last_ff, last_in;

   logic [VALUE_BITS-1:0] operand;
   logic                  operand_neg;
   logic [BCD_W-1:0]      bcd_adj;
   logic [3:0]            top_digit;

   assign operand     = raw_value[VALUE_BITS-1:0];
   assign operand_neg = sign_mode & operand[VALUE_BITS-1];
   assign top_digit   = bcd_ff[BCD_W-1 -: 4];

   // Add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_ff[d*4 +: 4] >= 4'd5) begin
            bcd_adj[d*4 +: 4] = bcd_ff[d*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[d*4 +: 4] = bcd_ff[d*4 +: 4];
         end
      end
   end

   always_comb begin
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      neg_in     = neg_ff;
      char_in    = char_ff;
      last_in    = last_ff;
      if (cmd.load) begin
         bin_in     = operand_neg ? (~operand + VALUE_BITS'(1)) : operand;
         bcd_in     = '0;
         bit_cnt_in = CNT_W'(VALUE_BITS);
         dig_cnt_in = DIG_W'(DIGITS);
         neg_in     = operand_neg;
      end
      if (cmd.shift) begin
         {bcd_in, bin_in} = {bcd_adj[BCD_W-2:0], bin_ff, 1'b0};
         bit_cnt_in       = bit_cnt_ff - CNT_W'(1);
      end
      if (cmd.skip || cmd.emit_digit) begin
         bcd_in     = {bcd_ff[BCD_W-5:0], 4'd0};
         dig_cnt_in = dig_cnt_ff - DIG_W'(1);
      end
      if (cmd.emit_sign) begin
         char_in = CHAR_MINUS;
         last_in = 1'b0;
      end
      if (cmd.emit_digit) begin
         char_in = CHAR_ZERO + CHAR_W'(top_digit);
         last_in = sts.one_left;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff     <= bin_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
      neg_ff     <= neg_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign sts.neg        = neg_ff;
   assign sts.last_shift = (bit_cnt_ff == CNT_W'(1));
   assign sts.top_zero   = (top_digit == 4'd0);
   assign sts.one_left   = (dig_cnt_ff == DIG_W'(1));

   assign out_char = char_ff;
   assign out_last = last_ff;

   // A finished conversion never leaves a digit above nine
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_digit |-> (top_digit <= 4'd9))
      else $error("BCD digit out of range at emission");

   // Leading zeros are dropped only while more than one digit remains
   a_skip_keeps_one: assert property (@(posedge clock) disable iff (reset)
      cmd.skip |-> (dig_cnt_ff > DIG_W'(1)))
      else $error("leading zero skip consumed the last digit");

   // A load arms the full shift count
   a_load_count: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (bit_cnt_ff == CNT_W'(VALUE_BITS)))
      else $error("bit counter not armed after load");

endmodule

// ----- rtl/core/i2da_controller.sv -----
module i2da_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  i2da_pkg::status_type  sts,
   output i2da_pkg::cmd_type     cmd
);
   import i2da_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            if (!sts.neg) begin
               state_in = ST_CONV;
            end else if (slot_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.shift = 1'b1;
            if (sts.last_shift) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (sts.top_zero && !sts.one_left) begin
               cmd.skip = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               cmd.emit_digit = 1'b1;
               if (sts.one_left) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit_sign || cmd.emit_digit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Never overwrite a character that is still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_sign || cmd.emit_digit) |-> slot_free)
      else $error("output register overwritten while stalled");

   // Every loaded character shows up as a valid transaction
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_sign || cmd.emit_digit) |=> rsp_valid_ff)
      else $error("emitted character not presented");

   // The final digit closes the item
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_digit && sts.one_left) |=> (state_ff == ST_IDLE))
      else $error("controller did not return to idle after last digit");

endmodule

// ----- rtl/core/int64_to_decimal_ascii_unit.sv -----
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_raw_value[63:0], req_sign_mode
// rsp       out        rsp_valid/rsp_stall  rsp_text_char[7:0], rsp_last_char
//
// One transaction in yields one to twenty character transactions out.
// Steps per item: one accept, one sign, VALUE_BITS double-dabble shifts (one bit per
// cycle), one step to leave the zero strip, then one step per dropped leading zero or
// emitted digit (DIGITS in total, 20 at 64 bits). The shared dabble register sets the
// rate, and output stalls add cycles on the sign and on each digit.
// Reset is synchronous and clears the controller and the output valid flag.
// A stalled character holds in the output register; the next item is accepted
// as soon as the last character of the current one sits in that register.
module int64_to_decimal_ascii_unit #(
   parameter int VALUE_BITS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [i2da_pkg::RAW_W-1:0]   req_raw_value,
   input  logic                         req_sign_mode,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [i2da_pkg::CHAR_W-1:0]  rsp_text_char,
   output logic                         rsp_last_char
);
   import i2da_pkg::*;

   cmd_type    cmd;
   status_type sts;

   // Sequencer: accept, sign, shift, strip leading zeros, emit digits
   i2da_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Magnitude, BCD shift register and the output character register
   i2da_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .raw_value (req_raw_value),
      .sign_mode (req_sign_mode),
      .cmd       (cmd),
      .sts       (sts),
      .out_char  (rsp_text_char),
      .out_last  (rsp_last_char)
   );

endmodule

// ----- test/tb_int64_to_decimal_ascii_unit.sv -----
module tb_int64_to_decimal_ascii_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import i2da_pkg::*;

   localparam int VALUE_BITS  = 64;
   localparam int HALF_PERIOD = 1;
   localparam int RESET_CYCLES = 12;
   // Long receiver hold-off that backs the block up into its input channel
   localparam int HOLD_CYCLES = 400;
   // Wait past the worst-case item plus stalls once nothing is pending
   localparam int DRAIN_CYCLES = 200;
   // Hang guard: ~550 items fit well inside this limit even with heavy stalls
   localparam int unsigned CYCLE_LIMIT = 1_000_000;

   typedef struct packed {
      logic [CHAR_W-1:0] text;
      logic              last;
   } expected_char_type;

   // Expected decimal text of every accepted operand, one entry per character,
   // checked in order against the character transactions leaving the block.
   class decimal_text_board_type;
      expected_char_type expected_chars[$];
      int unsigned operands;
      int unsigned negatives;
      int unsigned chars_checked;
      int unsigned longest;
      int unsigned errors;

      function void note_operand(logic [RAW_W-1:0] raw, logic sign_mode);
         logic [RAW_W-1:0] mask;
         logic [RAW_W-1:0] mag;
         logic [3:0]       digits [0:19];
         int               count;
         logic             neg;
         mask = {RAW_W{1'b1}} >> (RAW_W - VALUE_BITS);
         mag = raw & mask;
         neg = sign_mode && mag[VALUE_BITS-1];
         if (neg) begin
            mag = (~mag + 1'b1) & mask;
            negatives++;
            expected_chars.push_back('{text: CHAR_MINUS, last: 1'b0});
         end
         count = 0;
         do begin
            digits[count] = 4'(mag % 10);
            mag = mag / 10;
            count++;
         end while (mag != 0 && count < 20);
         for (int k = count - 1; k >= 0; k--) begin
            expected_chars.push_back('{text: CHAR_ZERO + CHAR_W'(digits[k]), last: k == 0});
         end
         if (count + int'(neg) > longest) begin
            longest = count + int'(neg);
         end
         operands++;
      endfunction

      function void check_char(logic [CHAR_W-1:0] text, logic last);
         expected_char_type want;
         chars_checked++;
         if (expected_chars.size() == 0) begin
            errors++;
            $display("%0t: unexpected character %h (last %b) with nothing pending",
                     $time, text, last);
            return;
         end
         want = expected_chars.pop_front();
         if (text !== want.text) begin
            errors++;
            $display("%0t: text_char expected %h got %h", $time, want.text, text);
         end
         if (last !== want.last) begin
            errors++;
            $display("%0t: last_char expected %b got %b", $time, want.last, last);
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [RAW_W-1:0]    req_raw_value = '0;
   logic                req_sign_mode = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CHAR_W-1:0]   rsp_text_char;
   logic                rsp_last_char;

   decimal_text_board_type board;
   int unsigned idle_pct = 0;      // sender idle chance per item slot
   int unsigned stall_pct = 0;     // receiver stall chance per cycle
   int unsigned holds_requested = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;

   int64_to_decimal_ascii_unit #(
      .VALUE_BITS(VALUE_BITS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_raw_value (req_raw_value),
      .req_sign_mode (req_sign_mode),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for
   // one. The hold is counted here so the sender keeps running independently.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_requested) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         holds_served <= holds_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Sample the result channel mid-cycle, where everything is settled for the
   // coming edge; a valid, unstalled character transfers at that edge.
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_char(rsp_text_char, rsp_last_char);
      end
   end

   function automatic logic [RAW_W-1:0] mask_bits(int unsigned width);
      return {RAW_W{1'b1}} >> (RAW_W - width);
   endfunction

   // Offer one operand and hold it until the block takes it. Valid stays high
   // into the next call when there is no gap, so it is never dropped and raised
   // in the same step.
   task automatic offer_operand(logic [RAW_W-1:0] raw, logic sign_mode);
      logic took;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < idle_pct);
      end
      req_valid     <= 1'b1;
      req_raw_value <= raw;
      req_sign_mode <= sign_mode;
      do begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
      end while (!took);
      board.note_operand(raw, sign_mode);
   endtask

   // Random operand, biased toward digit-count boundaries and the edges of
   // both number ranges so that every text length shows up often.
   function automatic logic [RAW_W-1:0] pick_operand();
      logic [RAW_W-1:0] power;
      logic [RAW_W-1:0] base;
      logic [RAW_W-1:0] value;
      case ($urandom_range(4))
         0: value = {$urandom, $urandom};
         1: value = {$urandom, $urandom} & mask_bits($urandom_range(1, 64));
         2: begin
            power = 1;
            repeat ($urandom_range(0, 19)) power = power * 10;
            value = power - 64'd2 + 64'($urandom_range(0, 4));
         end
         3: value = -({$urandom, $urandom} & mask_bits($urandom_range(1, 64)));
         default: begin
            case ($urandom_range(3))
               0: base = '0;
               1: base = '1;
               2: base = {1'b1, {(RAW_W-1){1'b0}}};
               default: base = {1'b0, {(RAW_W-1){1'b1}}};
            endcase
            value = base - 64'd3 + 64'($urandom_range(0, 6));
         end
      endcase
      return value;
   endfunction

   task automatic run_random(int unsigned count, int unsigned idle, int unsigned stall);
      idle_pct  = idle;
      stall_pct = stall;
      repeat (count) offer_operand(pick_operand(), 1'($urandom_range(1)));
   endtask

   initial begin
      board = new;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero both ways, digit-count boundaries, unsigned maximum,
      // most negative and most positive signed values, small negatives.
      offer_operand(64'd0, 1'b0);
      offer_operand(64'd0, 1'b1);
      offer_operand(64'd1, 1'b0);
      offer_operand(64'd9, 1'b1);
      offer_operand(64'd10, 1'b0);
      offer_operand(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      offer_operand(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      offer_operand(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
      offer_operand(64'hFFFF_FFFF_FFFF_FFF6, 1'b1);
      offer_operand(64'h8000_0000_0000_0000, 1'b1);
      offer_operand(64'h8000_0000_0000_0000, 1'b0);
      offer_operand(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
      offer_operand(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      offer_operand(64'h8000_0000_0000_0001, 1'b1);
      offer_operand(64'd9999999999999999999, 1'b0);
      offer_operand(64'd10000000000000000000, 1'b0);
      offer_operand(64'd10000000000000000000, 1'b1);
      offer_operand(64'd999999999999999999, 1'b1);
      offer_operand(64'd1000000000000000000, 1'b1);
      offer_operand(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      offer_operand(64'h5555_5555_5555_5555, 1'b1);
      offer_operand(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);

      // Random phases with different idling on each side
      run_random(125, 0, 0);
      run_random(125, 72, 0);
      run_random(125, 0, 72);
      run_random(125, 10, 10);

      // Hold off the receiver while the sender streams without gaps
      idle_pct = 0;
      stall_pct = 0;
      holds_requested = holds_requested + 1;
      run_random(30, 0, 0);
      req_valid <= 1'b0;

      // Drain: everything accepted must come out
      while (board.expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.expected_chars.size() != 0) begin
         board.errors++;
         $display("%0t: %0d expected characters never arrived",
                  $time, board.expected_chars.size());
      end
      $display("Converted %0d operands (%0d negative), checked %0d characters,",
               board.operands, board.negatives, board.chars_checked);
      $display("longest text %0d characters, under four idling mixes and a long stall.",
               board.longest);
      if (board.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/i2da_pkg.sv
rtl/core/i2da_datapath.sv
rtl/core/i2da_controller.sv
rtl/core/int64_to_decimal_ascii_unit.sv
test/tb_int64_to_decimal_ascii_unit.sv
